// ===== sv/gpms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpms_pkg: shared types and constants for the greedy pair-match scorer
// Holds the request and result payloads, the chain slot type, the state
// encoding and the ordering function used by the chain cells.
// ----------------------------------------------------------------------------
package gpms_pkg;

    // Array geometry.
    localparam int MAX_SIDE      = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int SIDE_BITS     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_CNT_BITS = $clog2(MAX_SIDE + 1);
    localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_BITS     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COUNT_BITS    = $clog2(STORE_DEPTH + 1);
    localparam int CHAIN_LEN     = (MAX_SIDE > 1) ? MAX_SIDE : 2;

    // Fixed field widths.
    localparam int DIM_W   = 5;
    localparam int PW_W    = 16;
    localparam int TOTAL_W = 16;
    localparam int SUM_W   = 20;
    localparam int SCORE_W = 17;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROW_COUNT = 1'b0;
    localparam t_cfg_idx CFG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic [PW_W-1:0]    pair_weight;
        logic               is_last;
        logic [TOTAL_W-1:0] total_aligned;
    } t_request;

    typedef struct packed {
        logic [SUM_W-1:0]   matched_sum;
        logic [SCORE_W-1:0] score_q16;
        logic               zero_total;
    } t_result;

    // One candidate pair travelling along the chain.
    typedef struct packed {
        logic                   vld;
        logic [WEIGHT_BITS-1:0] w;
        logic [SIDE_BITS-1:0]   r;
        logic [SIDE_BITS-1:0]   c;
    } t_slot;

    typedef struct packed {
        logic insert;
        logic unload;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UNLOAD,
        ST_DIVIDE
    } t_state;

    // True when pair a comes before pair b in greedy order: heavier first,
    // and on equal weight the earlier row-major position first.
    function automatic logic precedes(input t_slot a, input t_slot b);
        logic res;
        res = (a.w > b.w) || ((a.w == b.w) && ({a.r, a.c} < {b.r, b.c}));
        return res;
    endfunction

    // A dimension of zero acts as one; anything above the maximum acts as it.
    function automatic logic [SIDE_CNT_BITS-1:0] clamp_side(input logic [DIM_W-1:0] v);
        logic [SIDE_CNT_BITS-1:0] res;
        if (v == '0) begin
            res = SIDE_CNT_BITS'(1);
        end else if (32'(v) > MAX_SIDE) begin
            res = SIDE_CNT_BITS'(MAX_SIDE);
        end else begin
            res = SIDE_CNT_BITS'(v);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/gpms_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpms_cell: one cell of the sorting chain
// In insert mode the cell keeps the better of its held pair and the arriving
// pair and passes the other on; in unload mode it takes its right neighbor's
// pair so that the chain drains toward cell zero in greedy order.
// ----------------------------------------------------------------------------
module gpms_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpms_pkg::t_cell_ctl i_ctl,
    input  gpms_pkg::t_slot   i_fwd,
    input  gpms_pkg::t_slot   i_back,
    output gpms_pkg::t_slot   o_held,
    output gpms_pkg::t_slot   o_pass
);
    import gpms_pkg::*;

    t_slot r_held;
    t_slot n_held;
    t_slot r_pass;
    t_slot n_pass;

    // Compare and swap, or shift toward the head.
    always_comb begin
        n_held     = r_held;
        n_pass     = r_pass;
        n_pass.vld = 1'b0;
        if (i_ctl.unload) begin
            n_held = i_back;
        end else if (i_ctl.insert && i_fwd.vld) begin
            if (!r_held.vld) begin
                n_held = i_fwd;
            end else if (precedes(i_fwd, r_held)) begin
                n_held = i_fwd;
                n_pass = r_held;
            end else begin
                n_pass = i_fwd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pass <= '0;
        end else begin
            r_held <= n_held;
            r_pass <= n_pass;
        end
    end

    assign o_held = r_held;
    assign o_pass = r_pass;

endmodule
`default_nettype wire

// ===== sv/gpms_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpms_div: score divider
// Restoring division of the matched sum, shifted up by sixteen bits, by the
// total; one quotient bit per cycle, with zero-total and saturation handled
// up front.
// ----------------------------------------------------------------------------
module gpms_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gpms_pkg::SUM_W-1:0]    i_sum,
    input  logic [gpms_pkg::TOTAL_W-1:0]  i_total,
    output logic                          o_done,
    output logic [gpms_pkg::SCORE_W-1:0]  o_score,
    output logic                          o_zero
);
    import gpms_pkg::*;

    localparam int CNT_W = $clog2(SCORE_W + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [TOTAL_W-1:0]   r_rem;
    logic                 r_lsb;
    logic [TOTAL_W-1:0]   r_div;
    logic [SCORE_W-1:0]   r_q;
    logic                 r_done;
    logic                 r_zero;
    logic [TOTAL_W:0]     w_shift;
    logic                 w_ge;

    // Partial remainder with the next dividend bit brought in.
    assign w_shift = {r_rem, r_lsb};
    assign w_ge    = w_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_total == '0) begin
                    r_done <= 1'b1;
                end else if (i_sum >= SUM_W'({i_total, 1'b0})) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(SCORE_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient, remainder and flags.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_total;
            r_zero <= (i_total == '0);
            r_rem  <= TOTAL_W'(i_sum >> 1);
            r_lsb  <= i_sum[0];
            if (i_total == '0) begin
                r_q <= '0;
            end else if (i_sum >= SUM_W'({i_total, 1'b0})) begin
                r_q <= SCORE_MAX;
            end else begin
                r_q <= '0;
            end
        end else if (r_busy) begin
            r_lsb <= 1'b0;
            if (w_ge) begin
                r_rem <= TOTAL_W'(w_shift - {1'b0, r_div});
                r_q   <= {r_q[SCORE_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[TOTAL_W-1:0];
                r_q   <= {r_q[SCORE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done  = r_done;
    assign o_score = r_q;
    assign o_zero  = r_zero;

endmodule
`default_nettype wire

// ===== sv/greedy_pair_match_score.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_pair_match_score: greedy pair matching and score
// Loads a weight matrix row-major, matches pairs greedily from heaviest to
// lightest and reports the matched sum and its ratio to a given total.
// ----------------------------------------------------------------------------
// Usage:
// - Requests (one matrix entry each) are taken on a clock edge where start
//   is high and busy is low. Entries load at one per cycle. The entry with
//   is_last set starts the matching and raises busy.
// - Matching runs in rounds. Each round scans the stored matrix, one entry
//   per cycle from the single read port, into a chain of sorting cells that
//   keeps the best free pairs, then unloads the chain one pair per cycle.
//   There are at most min(rows, cols) + 1 rounds. The divider then forms the
//   score, taking a short path for a zero total or a saturated score, and
//   the result shows in the cycle after it is done.
// - The result shows on o_result for one cycle with o_strobe high, and busy
//   falls in the same cycle; the receiver cannot stall it.
// - The register port writes row_count (index 0) and col_count (index 1)
//   at any edge with i_cfg_we high; write only while busy is low.
// - Reset sets both dimensions to one and clears the load position. The
//   weight store keeps no reset value.
// ----------------------------------------------------------------------------
module greedy_pair_match_score (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gpms_pkg::t_request               i_request,
    output logic                             o_strobe,
    output gpms_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  gpms_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [gpms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gpms_pkg::*;

    localparam int DRAIN_CYCLES = CHAIN_LEN + 3;
    localparam int DRAIN_BITS   = $clog2(DRAIN_CYCLES);
    localparam logic [DRAIN_BITS-1:0] DRAIN_LAST = DRAIN_BITS'(DRAIN_CYCLES - 1);
    localparam int SUM_ADD_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

    t_state                    r_state;
    t_state                    n_state;
    logic [DIM_W-1:0]          r_row_count;
    logic [DIM_W-1:0]          r_col_count;
    logic [ADDR_BITS-1:0]      r_load_pos;
    logic [WEIGHT_BITS-1:0]    r_mem [STORE_DEPTH];
    logic [SIDE_CNT_BITS-1:0]  r_rows;
    logic [SIDE_CNT_BITS-1:0]  r_cols;
    logic [TOTAL_W-1:0]        r_total;
    logic [MAX_SIDE-1:0]       r_row_used;
    logic [MAX_SIDE-1:0]       r_col_used;
    logic [SUM_W-1:0]          r_sum;
    t_slot                     r_bound;
    logic                      r_have_bound;
    logic                      r_round_any;
    logic [ADDR_BITS-1:0]      r_scan_addr;
    logic [SIDE_BITS-1:0]      r_scan_r;
    logic [SIDE_BITS-1:0]      r_scan_c;
    logic [DRAIN_BITS-1:0]     r_cnt;
    logic                      r_rd_vld;
    logic [WEIGHT_BITS-1:0]    r_rd_w;
    logic [SIDE_BITS-1:0]      r_rd_r;
    logic [SIDE_BITS-1:0]      r_rd_c;
    t_slot                     r_feed;
    logic                      r_strobe;
    t_result                   r_result;

    logic                      w_accept;
    logic                      w_match_start;
    logic [COUNT_BITS-1:0]     w_entries;
    logic                      w_store;
    logic                      w_col_end;
    logic                      w_scan_last;
    logic                      w_scan_step;
    logic                      w_scan_restart;
    logic                      w_take;
    logic                      w_head_seen;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [SCORE_W-1:0]        w_div_score;
    logic                      w_div_zero;
    t_cell_ctl                 w_ctl;
    t_slot                     w_rd_slot;
    logic                      w_eligible;
    logic [SUM_ADD_W-1:0]      w_sum_wide;
    logic [SUM_W-1:0]          w_sum_next;
    t_slot                     w_held [CHAIN_LEN];
    t_slot                     w_pass [CHAIN_LEN];
    logic [CHAIN_LEN-1:0]      w_vld_vec;

    // Request handshake and load addressing.
    assign busy          = (r_state != ST_IDLE);
    assign w_accept      = start && !busy;
    assign w_match_start = w_accept && i_request.is_last;
    assign w_entries     = COUNT_BITS'(clamp_side(r_row_count))
                         * COUNT_BITS'(clamp_side(r_col_count));
    assign w_store       = w_accept && (COUNT_BITS'(r_load_pos) < w_entries);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_W'(1);
            r_col_count <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
            endcase
        end
    end

    // Weight store: written while loading, read once per cycle while scanning.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_load_pos] <= WEIGHT_BITS'(i_request.pair_weight);
        end
        r_rd_w <= r_mem[r_scan_addr];
    end

    // Load position, cleared when a matching starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
        end else if (w_match_start) begin
            r_load_pos <= '0;
        end else if (w_store) begin
            r_load_pos <= r_load_pos + ADDR_BITS'(1);
        end
    end

    // Scan position tracking.
    assign w_col_end   = (SIDE_CNT_BITS'(r_scan_c) == r_cols - SIDE_CNT_BITS'(1));
    assign w_scan_last = w_col_end && (SIDE_CNT_BITS'(r_scan_r) == r_rows - SIDE_CNT_BITS'(1));

    // Next state and per-state control.
    always_comb begin
        n_state        = r_state;
        w_ctl          = '0;
        w_scan_step    = 1'b0;
        w_scan_restart = 1'b0;
        w_take         = 1'b0;
        w_head_seen    = 1'b0;
        w_div_start    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_match_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_ctl.insert = 1'b1;
                w_scan_step  = 1'b1;
                if (w_scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                w_ctl.insert = 1'b1;
                if (r_cnt == DRAIN_LAST) begin
                    n_state = ST_UNLOAD;
                end
            end
            ST_UNLOAD: begin
                w_ctl.unload = 1'b1;
                if (w_held[0].vld) begin
                    w_head_seen = 1'b1;
                    w_take      = !r_row_used[w_held[0].r] && !r_col_used[w_held[0].c];
                end else if (r_round_any) begin
                    n_state        = ST_SCAN;
                    w_scan_restart = 1'b1;
                end else begin
                    n_state     = ST_DIVIDE;
                    w_div_start = 1'b1;
                end
            end
            ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan counters and drain counter.
    always_ff @(posedge i_clk) begin
        if (w_match_start || w_scan_restart) begin
            r_scan_addr <= '0;
            r_scan_r    <= '0;
            r_scan_c    <= '0;
        end else if (w_scan_step) begin
            r_scan_addr <= r_scan_addr + ADDR_BITS'(1);
            if (w_col_end) begin
                r_scan_c <= '0;
                r_scan_r <= r_scan_r + SIDE_BITS'(1);
            end else begin
                r_scan_c <= r_scan_c + SIDE_BITS'(1);
            end
        end
        if (r_state == ST_DRAIN) begin
            r_cnt <= r_cnt + DRAIN_BITS'(1);
        end else begin
            r_cnt <= '0;
        end
    end

    // Read stage and eligibility filter in front of the chain.
    assign w_rd_slot  = '{vld: r_rd_vld, w: r_rd_w, r: r_rd_r, c: r_rd_c};
    assign w_eligible = r_rd_vld && !r_row_used[r_rd_r] && !r_col_used[r_rd_c]
                     && (!r_have_bound || precedes(r_bound, w_rd_slot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_feed   <= '0;
        end else begin
            r_rd_vld <= w_scan_step;
            r_feed   <= '{vld: w_eligible, w: r_rd_w, r: r_rd_r, c: r_rd_c};
        end
        r_rd_r <= r_scan_r;
        r_rd_c <= r_scan_c;
    end

    // Chain of sorting cells; cell zero holds the best pair.
    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
        t_slot w_fwd_in;
        t_slot w_back_in;
        if (k == 0) begin : g_first
            assign w_fwd_in = r_feed;
        end else begin : g_inner
            assign w_fwd_in = w_pass[k-1];
        end
        if (k == CHAIN_LEN - 1) begin : g_last
            assign w_back_in = '0;
        end else begin : g_mid
            assign w_back_in = w_held[k+1];
        end
        gpms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_fwd   (w_fwd_in),
            .i_back  (w_back_in),
            .o_held  (w_held[k]),
            .o_pass  (w_pass[k])
        );
        assign w_vld_vec[k] = w_held[k].vld;
    end

    // Saturating accumulation of taken weights.
    assign w_sum_wide = SUM_ADD_W'(r_sum) + SUM_ADD_W'(w_held[0].w);
    assign w_sum_next = (w_sum_wide > SUM_ADD_W'(SUM_MAX)) ? SUM_MAX
                                                          : SUM_W'(w_sum_wide);

    // Matching state: dimensions, used rows and columns, sum, round bound.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_used   <= '0;
            r_col_used   <= '0;
            r_sum        <= '0;
            r_have_bound <= 1'b0;
            r_round_any  <= 1'b0;
        end else if (w_match_start) begin
            r_row_used   <= '0;
            r_col_used   <= '0;
            r_sum        <= '0;
            r_have_bound <= 1'b0;
            r_round_any  <= 1'b0;
        end else begin
            if (w_scan_restart) begin
                r_round_any <= 1'b0;
            end else if (w_head_seen) begin
                r_round_any  <= 1'b1;
                r_have_bound <= 1'b1;
            end
            if (w_take) begin
                r_row_used[w_held[0].r] <= 1'b1;
                r_col_used[w_held[0].c] <= 1'b1;
                r_sum                   <= w_sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match_start) begin
            r_rows  <= clamp_side(r_row_count);
            r_cols  <= clamp_side(r_col_count);
            r_total <= i_request.total_aligned;
        end
        if (w_head_seen) begin
            r_bound <= w_held[0];
        end
    end

    // Score division.
    gpms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_sum),
        .i_total (r_total),
        .o_done  (w_div_done),
        .o_score (w_div_score),
        .o_zero  (w_div_zero)
    );

    // Result register, shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_DIVIDE) && w_div_done;
        end
        if ((r_state == ST_DIVIDE) && w_div_done) begin
            r_result <= '{matched_sum: r_sum, score_q16: w_div_score,
                          zero_total: w_div_zero};
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Each matching yields a single one-cycle result.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for more than one cycle");

    // Rows and columns are always marked used in pairs.
    a_used_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_row_used) == $countones(r_col_used))
        else $error("row and column use counts differ");

    // Occupied cells form an unbroken run from the head of the chain.
    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld_vec & (w_vld_vec + CHAIN_LEN'(1))) == '0)
        else $error("gap in sorting chain");

    // The head never falls behind its neighbor while unloading.
    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UNLOAD) && w_held[1].vld |-> precedes(w_held[0], w_held[1]))
        else $error("sorting chain out of order");

    // A result only appears once the block has returned to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle");

endmodule
`default_nettype wire
